// ===== rtl/core/tlfs_pkg.sv =====
// Shared types, codes and helpers for the three-level feedback scheduler.
package tlfs_pkg;

   localparam int ID_W    = 8;
   localparam int SVC_W   = 8;
   localparam int QUANT_W = 3;
   localparam int LEVEL_W = 2;
   localparam int LEVELS  = 3;

   // request kinds
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // priority levels
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MIDDLE = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd2;

   // register indexes
   localparam logic CSR_MIDDLE_QUANTUM = 1'b0;
   localparam logic CSR_LOW_QUANTUM    = 1'b1;

   localparam logic [QUANT_W-1:0] MIDDLE_QUANTUM_RESET = 3'd2;
   localparam logic [QUANT_W-1:0] LOW_QUANTUM_RESET    = 3'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [SVC_W-1:0] svc;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // server -> queue side
   typedef struct packed {
      logic               requeue;
      logic [LEVEL_W-1:0] requeue_level;
      job_type            requeue_job;
      logic               take;
   } srv_ctl_type;

   // per-tick outcome from the server
   typedef struct packed {
      logic            slot_busy;
      logic [ID_W-1:0] served_id;
      logic            job_done;
   } srv_res_type;

   // quantum of a level; a zero register acts as one slot
   function automatic logic [QUANT_W-1:0] quantum_of(
      input logic [LEVEL_W-1:0] level,
      input logic [QUANT_W-1:0] mid_q,
      input logic [QUANT_W-1:0] low_q
   );
      logic [QUANT_W-1:0] q;
      q = QUANT_W'(1);
      if (level == LEVEL_MIDDLE) q = mid_q;
      else if (level != LEVEL_HIGH) q = low_q;
      if (q == '0) q = QUANT_W'(1);
      return q;
   endfunction

endpackage

// ===== rtl/core/tlfs_fifo.sv =====
// One priority-level job FIFO: register storage, head/tail/count.
module tlfs_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlfs_pkg::job_type      push_job,
   input  logic                   pop,
   output tlfs_pkg::job_type      head_job,
   output tlfs_pkg::fifo_stat_type stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   tlfs_pkg::job_type mem_ff [FIFO_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_job;
      end
   end

   // empty FIFO being pushed and popped together hands the new job straight through
   assign head_job   = (count_ff == '0) ? push_job : mem_ff[head_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_FULL);

endmodule

// ===== rtl/core/tlfs_server.sv =====
// Server state: current job, quantum countdown, demotion and re-queue.
module tlfs_server (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick,
   input  logic [tlfs_pkg::QUANT_W-1:0]        mid_quantum,
   input  logic [tlfs_pkg::QUANT_W-1:0]        low_quantum,
   input  logic                                sel_valid,
   input  logic [tlfs_pkg::LEVEL_W-1:0]        sel_level,
   input  tlfs_pkg::job_type                   sel_job,
   output tlfs_pkg::srv_ctl_type               ctl,
   output tlfs_pkg::srv_res_type               res
);

   logic [tlfs_pkg::ID_W-1:0]    job_ff, job_in;
   logic [tlfs_pkg::SVC_W-1:0]   rem_ff, rem_in;
   logic [tlfs_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [tlfs_pkg::QUANT_W-1:0] slots_ff, slots_in;
   logic                         busy_ff, busy_in;
   logic                         requeue_ff, requeue_in;

   logic                         take;
   logic                         active;
   logic [tlfs_pkg::ID_W-1:0]    cur_job;
   logic [tlfs_pkg::SVC_W-1:0]   cur_rem;
   logic [tlfs_pkg::LEVEL_W-1:0] cur_level;
   logic [tlfs_pkg::QUANT_W-1:0] cur_slots;
   logic [tlfs_pkg::QUANT_W-1:0] slots_dec;

   assign take      = tick && !busy_ff && sel_valid;
   assign active    = busy_ff || take;
   assign cur_job   = take ? sel_job.id  : job_ff;
   assign cur_rem   = take ? sel_job.svc : rem_ff;
   assign cur_level = take ? sel_level   : level_ff;
   assign cur_slots = take ? tlfs_pkg::quantum_of(sel_level, mid_quantum, low_quantum)
                           : slots_ff;
   assign slots_dec = cur_slots - tlfs_pkg::QUANT_W'(1);

   always_comb begin
      job_in     = cur_job;
      rem_in     = cur_rem;
      level_in   = cur_level;
      slots_in   = cur_slots;
      busy_in    = active;
      requeue_in = requeue_ff && !tick;
      res        = '0;
      if (tick && active) begin
         res.slot_busy = 1'b1;
         res.served_id = cur_job;
         if (cur_rem <= tlfs_pkg::SVC_W'(1)) begin
            rem_in       = '0;
            res.job_done = 1'b1;
            busy_in      = 1'b0;
         end else begin
            rem_in   = cur_rem - tlfs_pkg::SVC_W'(1);
            slots_in = slots_dec;
            if (slots_dec == '0) begin
               busy_in    = 1'b0;
               requeue_in = 1'b1;
               if (cur_level != tlfs_pkg::LEVEL_LOW) begin
                  level_in = cur_level + tlfs_pkg::LEVEL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff     <= '0;
         rem_ff     <= '0;
         level_ff   <= tlfs_pkg::LEVEL_HIGH;
         slots_ff   <= '0;
         busy_ff    <= 1'b0;
         requeue_ff <= 1'b0;
      end else begin
         job_ff     <= job_in;
         rem_ff     <= rem_in;
         level_ff   <= level_in;
         slots_ff   <= slots_in;
         busy_ff    <= busy_in;
         requeue_ff <= requeue_in;
      end
   end

   assign ctl.requeue       = tick && requeue_ff;
   assign ctl.requeue_level = level_ff;
   assign ctl.requeue_job   = '{id: job_ff, svc: rem_ff};
   assign ctl.take          = take;

endmodule

// ===== rtl/core/three_level_feedback_scheduler.sv =====
// Top level of the three-level feedback scheduler: request register, queues, server, response register.
//
//   channel   ports                                         direction  handshake
//   request   start, busy, req_kind/job_id/job_class/...    in         start && !busy
//   response  rsp_valid, rsp_slot_busy/served_id/job_done/  out        rsp_valid, one cycle
//             rsp_dropped
//   csr       csr_write_enable, csr_index, csr_write_data   in         write enable, no wait
//
// One request per cycle, every cycle: busy is always low.
// A request is taken into the request register and processed from there (re-queue push,
// priority pick with pass-through of a just-pushed job, one slot of service); its response
// is then registered in the response register and shows on the rsp_ ports from there.
// Reset clears queue pointers/counts, server state and restores the quantum registers
// to middle 2, low 3. The receiver cannot stall; every response is a one-cycle strobe.
module three_level_feedback_scheduler #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [tlfs_pkg::ID_W-1:0]          req_job_id,
   input  logic [1:0]                         req_job_class,
   input  logic [tlfs_pkg::SVC_W-1:0]         req_service_time,
   // response channel
   output logic                               rsp_valid,
   output logic                               rsp_slot_busy,
   output logic [tlfs_pkg::ID_W-1:0]          rsp_served_id,
   output logic                               rsp_job_done,
   output logic                               rsp_dropped,
   // register write port
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [tlfs_pkg::QUANT_W-1:0]       csr_write_data
);

   localparam int LEVELS = tlfs_pkg::LEVELS;

   // ---------------- quantum registers ----------------
   logic [tlfs_pkg::QUANT_W-1:0] mid_q_ff, low_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_q_ff <= tlfs_pkg::MIDDLE_QUANTUM_RESET;
         low_q_ff <= tlfs_pkg::LOW_QUANTUM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tlfs_pkg::CSR_MIDDLE_QUANTUM: mid_q_ff <= csr_write_data;
            tlfs_pkg::CSR_LOW_QUANTUM:    low_q_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- request register ----------------
   logic                       req_valid_ff;
   logic                       kind_ff;
   tlfs_pkg::job_type          arr_job_ff;
   logic [tlfs_pkg::LEVEL_W-1:0] arr_level_ff;
   logic [tlfs_pkg::LEVEL_W-1:0] arr_level_in;

   assign busy = 1'b0;

   // class three folds into the low queue
   assign arr_level_in = (req_job_class == 2'd3) ? tlfs_pkg::LEVEL_LOW : req_job_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff      <= req_kind;
         arr_job_ff   <= '{id: req_job_id, svc: req_service_time};
         arr_level_ff <= arr_level_in;
      end
   end

   logic arrival, tick;
   assign arrival = req_valid_ff && (kind_ff == tlfs_pkg::KIND_ARRIVAL);
   assign tick    = req_valid_ff && (kind_ff == tlfs_pkg::KIND_TICK);

   // ---------------- queues ----------------
   tlfs_pkg::srv_ctl_type   ctl;
   tlfs_pkg::srv_res_type   res;
   tlfs_pkg::fifo_stat_type stat     [LEVELS];
   tlfs_pkg::job_type       head_job [LEVELS];

   // at most one push per cycle: an arrival or the pending re-queue of a tick
   logic                         push_req;
   logic [tlfs_pkg::LEVEL_W-1:0] push_level;
   tlfs_pkg::job_type            push_job;
   logic [LEVELS-1:0]            push_ok;
   logic [LEVELS-1:0]            avail;
   logic [LEVELS-1:0]            pop;
   logic                         drop;

   always_comb begin
      push_req   = arrival || ctl.requeue;
      push_level = arrival ? arr_level_ff : ctl.requeue_level;
      push_job   = arrival ? arr_job_ff   : ctl.requeue_job;
      drop       = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         push_ok[l] = push_req && (push_level == tlfs_pkg::LEVEL_W'(l)) && !stat[l].full;
         avail[l]   = !stat[l].empty || push_ok[l];
         if (push_req && (push_level == tlfs_pkg::LEVEL_W'(l)) && stat[l].full) drop = 1'b1;
      end
   end

   // strict priority pick over queue contents after this cycle's push
   logic                         sel_valid;
   logic [tlfs_pkg::LEVEL_W-1:0] sel_level;
   tlfs_pkg::job_type            sel_job;

   always_comb begin
      sel_valid = 1'b1;
      sel_level = tlfs_pkg::LEVEL_HIGH;
      sel_job   = head_job[0];
      if (avail[0]) begin
         sel_level = tlfs_pkg::LEVEL_HIGH;
         sel_job   = head_job[0];
      end else if (avail[1]) begin
         sel_level = tlfs_pkg::LEVEL_MIDDLE;
         sel_job   = head_job[1];
      end else if (avail[2]) begin
         sel_level = tlfs_pkg::LEVEL_LOW;
         sel_job   = head_job[2];
      end else begin
         sel_valid = 1'b0;
      end
      for (int l = 0; l < LEVELS; l++) begin
         pop[l] = ctl.take && (sel_level == tlfs_pkg::LEVEL_W'(l));
      end
   end

   for (genvar g = 0; g < LEVELS; g++) begin : g_fifo
      tlfs_fifo #(
         .FIFO_DEPTH (FIFO_DEPTH)
      ) u_fifo (
         .clock    (clock),
         .reset    (reset),
         .push     (push_ok[g]),
         .push_job (push_job),
         .pop      (pop[g]),
         .head_job (head_job[g]),
         .stat     (stat[g])
      );
   end

   // ---------------- server ----------------
   tlfs_server u_server (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .mid_quantum (mid_q_ff),
      .low_quantum (low_q_ff),
      .sel_valid   (sel_valid),
      .sel_level   (sel_level),
      .sel_job     (sel_job),
      .ctl         (ctl),
      .res         (res)
   );

   // ---------------- response register ----------------
   logic                      rsp_valid_ff;
   tlfs_pkg::srv_res_type     rsp_res_ff;
   logic                      rsp_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // res is all zero on arrivals
   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_res_ff  <= res;
         rsp_drop_ff <= drop;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot_busy = rsp_res_ff.slot_busy;
   assign rsp_served_id = rsp_res_ff.served_id;
   assign rsp_job_done  = rsp_res_ff.job_done;
   assign rsp_dropped   = rsp_drop_ff;

endmodule
